### rtl/core/prefix_autocomplete_table_core_assert.svh
// Assertion helpers for the autocomplete table core.
`ifndef PREFIX_AUTOCOMPLETE_TABLE_CORE_ASSERT_SVH
`define PREFIX_AUTOCOMPLETE_TABLE_CORE_ASSERT_SVH

// Clocked check, masked while reset is held.
`define PAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds in the cycle after the trigger.
`define PAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  `PAT_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### rtl/core/pat_pkg.sv
package pat_pkg;

  localparam int WORD_BYTES = 21;
  localparam int WORD_BITS  = 8 * WORD_BYTES;
  localparam int LEN_BITS   = 5;

  localparam int DEF_ENTRIES    = 1024;
  localparam int DEF_MAX_CHARS  = 21;
  localparam int DEF_COUNT_BITS = 16;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    STAT_HIT  = 2'd0,
    STAT_NEW  = 2'd1,
    STAT_FULL = 2'd2
  } pat_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } pat_state_t;

  typedef struct packed {
    logic        op;
    logic [63:0] query_chunk0;
    logic [63:0] query_chunk1;
    logic [39:0] query_chunk2;
    logic [4:0]  query_length;
    logic        exact_request;
  } pat_in_t;

  typedef struct packed {
    logic [63:0] result_chunk0;
    logic [63:0] result_chunk1;
    logic [39:0] result_chunk2;
    logic [4:0]  result_length;
    logic [1:0]  status;
    logic [15:0] result_count;
  } pat_out_t;

  // Normalized word: bytes past the length are zero.
  typedef struct packed {
    logic                 op;
    logic                 exact;
    logic [WORD_BITS-1:0] word;
    logic [LEN_BITS-1:0]  len;
  } pat_item_t;

  // Head of the front queue as seen by the back end.
  typedef struct packed {
    logic      vld;
    pat_item_t item;
  } pat_queue_t;

endpackage

### rtl/core/pat_front.sv
module pat_front #(
  parameter int MAX_CHARS = pat_pkg::DEF_MAX_CHARS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pat_pkg::pat_in_t    in_data,
  input  logic                pop,
  output pat_pkg::pat_queue_t head
);
  import pat_pkg::*;

  localparam int LIM = (MAX_CHARS < WORD_BYTES) ? MAX_CHARS : WORD_BYTES;

  logic [LEN_BITS-1:0]  lim;
  logic [WORD_BITS-1:0] raw;
  logic [WORD_BITS-1:0] mask;
  pat_item_t            norm;
  pat_item_t            q_r [2];
  logic                 wp_r, rp_r;
  logic [1:0]           cnt_r;
  logic                 push, do_pop;

  always_comb begin
    lim = (in_data.query_length > LEN_BITS'(LIM)) ? LEN_BITS'(LIM) : in_data.query_length;
    raw = {in_data.query_chunk0, in_data.query_chunk1, in_data.query_chunk2};
    for (int i = 0; i < WORD_BYTES; i++) begin
      mask[WORD_BITS-1-8*i -: 8] = (LEN_BITS'(i) < lim) ? 8'hFF : 8'h00;
    end
    norm.op    = in_data.op;
    norm.exact = in_data.exact_request;
    norm.word  = raw & mask;
    norm.len   = lim;
  end

  assign busy   = (cnt_r == 2'd2);
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= norm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push)   wp_r <= ~wp_r;
      if (do_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(do_pop);
    end
  end

  assign head.vld  = (cnt_r != 2'd0);
  assign head.item = q_r[rp_r];

endmodule

### rtl/core/pat_back.sv
module pat_back #(
  parameter int ENTRIES    = pat_pkg::DEF_ENTRIES,
  parameter int COUNT_BITS = pat_pkg::DEF_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pat_pkg::pat_queue_t head,
  output logic                pop,
  output logic                out_valid,
  output pat_pkg::pat_out_t   out_data
);
  import pat_pkg::*;

  localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam int CW   = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [WORD_BITS-1:0]  mem_word [ENTRIES];
  logic [LEN_BITS-1:0]   mem_len  [ENTRIES];
  logic [COUNT_BITS-1:0] mem_uses [ENTRIES];

  pat_state_t state_r, state_nxt;
  logic [CNTW-1:0]       count_r, k_r;
  pat_item_t             cur_r;
  logic                  found_r;
  logic [AW-1:0]         best_idx_r, rd_idx_r;
  logic [WORD_BITS-1:0]  best_word_r, e_word_r;
  logic [LEN_BITS-1:0]   best_len_r, e_len_r;
  logic [COUNT_BITS-1:0] best_uses_r, e_uses_r;
  logic                  rd_vld_r;
  logic                  out_valid_r;
  pat_out_t              out_data_r;

  logic                  full, rd_en, we, hit, better, take;
  logic [AW-1:0]         wa;
  logic [WORD_BITS-1:0]  wd_word, qmask;
  logic [LEN_BITS-1:0]   wd_len;
  logic [COUNT_BITS-1:0] wd_uses, inc_uses;
  logic [CW-1:0]         cnt_ext;

  assign full     = (count_r == CNTW'(ENTRIES));
  assign inc_uses = (best_uses_r == '1) ? best_uses_r : best_uses_r + 1'b1;
  assign cnt_ext  = CW'(inc_uses);

  // Candidate evaluation on the registered read data.
  always_comb begin
    for (int i = 0; i < WORD_BYTES; i++) begin
      qmask[WORD_BITS-1-8*i -: 8] = (LEN_BITS'(i) < cur_r.len) ? 8'hFF : 8'h00;
    end
    if (cur_r.exact) begin
      hit = (e_len_r == cur_r.len) && (e_word_r == cur_r.word);
    end else begin
      hit = (e_len_r >= cur_r.len) && (((e_word_r ^ cur_r.word) & qmask) == '0);
    end
    better = !found_r || (e_uses_r > best_uses_r) ||
             ((e_uses_r == best_uses_r) && !cur_r.exact &&
              ((e_word_r < best_word_r) ||
               ((e_word_r == best_word_r) && (e_len_r < best_len_r))));
    take = rd_vld_r && hit && better;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (head.vld && head.item.op == OP_QUERY) state_nxt = ST_SCAN;
      ST_SCAN:   if (k_r == count_r) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    rd_en   = 1'b0;
    we      = 1'b0;
    wa      = count_r[AW-1:0];
    wd_word = head.item.word;
    wd_len  = head.item.len;
    wd_uses = '0;
    case (state_r)
      ST_IDLE: begin
        pop = head.vld;
        we  = head.vld && (head.item.op == OP_LOAD) && !full;
      end
      ST_SCAN: begin
        rd_en = (k_r != count_r);
      end
      ST_FINISH: begin
        we = found_r || !full;
        if (found_r) begin
          wa      = best_idx_r;
          wd_word = best_word_r;
          wd_len  = best_len_r;
          wd_uses = inc_uses;
        end else begin
          wd_word = cur_r.word;
          wd_len  = cur_r.len;
          wd_uses = COUNT_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_word[wa] <= wd_word;
      mem_len[wa]  <= wd_len;
      mem_uses[wa] <= wd_uses;
    end
    if (rd_en) begin
      e_word_r <= mem_word[k_r[AW-1:0]];
      e_len_r  <= mem_len[k_r[AW-1:0]];
      e_uses_r <= mem_uses[k_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= k_r[AW-1:0];
    if (state_r == ST_IDLE) begin
      cur_r <= head.item;
    end
    if (take) begin
      best_idx_r  <= rd_idx_r;
      best_word_r <= e_word_r;
      best_len_r  <= e_len_r;
      best_uses_r <= e_uses_r;
    end
    if (state_r == ST_FINISH) begin
      if (found_r) begin
        out_data_r.result_chunk0 <= best_word_r[WORD_BITS-1 -: 64];
        out_data_r.result_chunk1 <= best_word_r[WORD_BITS-65 -: 64];
        out_data_r.result_chunk2 <= best_word_r[39:0];
        out_data_r.result_length <= best_len_r;
        out_data_r.status        <= STAT_HIT;
        out_data_r.result_count  <= cnt_ext[15:0];
      end else begin
        out_data_r.result_chunk0 <= cur_r.word[WORD_BITS-1 -: 64];
        out_data_r.result_chunk1 <= cur_r.word[WORD_BITS-65 -: 64];
        out_data_r.result_chunk2 <= cur_r.word[39:0];
        out_data_r.result_length <= cur_r.len;
        out_data_r.status        <= full ? STAT_FULL : STAT_NEW;
        out_data_r.result_count  <= full ? 16'd0 : 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      found_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= (state_r == ST_FINISH);
      if (state_r == ST_IDLE) begin
        k_r     <= '0;
        found_r <= 1'b0;
      end
      if (rd_en) k_r <= k_r + 1'b1;
      if (take) found_r <= 1'b1;
      if (we && wa == count_r[AW-1:0] && !(state_r == ST_FINISH && found_r)) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/prefix_autocomplete_table_core.sv
// Load transaction: queued on acceptance, then written to the table (if not full) when the back
//   end takes it in idle, later when it waits behind a query; it gives no result.
// Query transaction: once taken from the queue, the back end passes scan, drain and finish;
//   the result strobe is registered from finish. It scans one stored entry per cycle through
//   a single table read port; the back end handles one transaction at a time.
// rst_n (synchronous, active low) empties the table and queue; results cannot be stalled.
module prefix_autocomplete_table_core #(
  parameter int ENTRIES    = pat_pkg::DEF_ENTRIES,
  parameter int MAX_CHARS  = pat_pkg::DEF_MAX_CHARS,
  parameter int COUNT_BITS = pat_pkg::DEF_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pat_pkg::pat_in_t  in_data,
  output logic              out_valid,
  output pat_pkg::pat_out_t out_data
);
  import pat_pkg::*;
  `include "prefix_autocomplete_table_core_assert.svh"

  // Front end: word normalization (length cap, padding cleared) and a two-deep queue
  // that takes new transactions while a scan runs; busy marks it full.
  pat_queue_t head;
  logic       pop;

  pat_front #(
    .MAX_CHARS(MAX_CHARS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_data(in_data),
    .pop    (pop),
    .head   (head)
  );

  // Back end: table storage, linear scan with ranking, count update, append.
  pat_back #(
    .ENTRIES   (ENTRIES),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // A result strobe lasts one cycle: the back end is already idle when it shows.
  `PAT_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe held")
  `PAT_ASSERT(a_status_code, out_valid |-> out_data.status != 2'd3, "bad status code")
  // A fresh insert always reports a count of one, a full table a count of zero.
  `PAT_ASSERT(a_new_count, out_valid && out_data.status == STAT_NEW |->
    out_data.result_count == 16'd1, "insert count not one")
  `PAT_ASSERT(a_full_count, out_valid && out_data.status == STAT_FULL |->
    out_data.result_count == 16'd0, "full count not zero")

endmodule
